[sv/cursor_overlay_compositor_assert.svh]
// assertion macros for the cursor overlay compositor
`ifndef CURSOR_OVERLAY_COMPOSITOR_ASSERT_SVH
`define CURSOR_OVERLAY_COMPOSITOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define COC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition that must never be seen
`define COC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/coc_pkg.sv]
// shared constants and helpers for the cursor overlay compositor
`timescale 1ns / 1ps

package coc_pkg;

  localparam int MAX_CURSOR_W_DEF = 64;
  localparam int MAX_CURSOR_H_DEF = 64;

  localparam int PIX_W   = 32;
  localparam int STORE_W = PIX_W + 1;
  localparam int COORD_W = 12;
  localparam int POS_W   = 13;
  localparam int SIZE_W  = 7;
  localparam int SCR_W   = 13;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [SCR_W-1:0] SCREEN_RST = 13'd4096;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_COMP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ENABLE  = 3'd6;

  // exact floor(p / 255) for any p up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = 17'(p) + 17'd1 + 17'(p[15:8]);
    return s[15:8];
  endfunction

endpackage

[sv/coc_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module coc_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/cursor_overlay_compositor.sv]
// top level of the cursor overlay compositor: pipeline, registers and cursor store
`timescale 1ns / 1ps
// Takes one beat per clock, either opcode, while in_stall is low and returns
// exactly one result per input beat, in order, through registers s1-s3 and out.
// Load beats write a pixel and its mask bit into the cursor store (one RAM of
// MAX_CURSOR_W * MAX_CURSOR_H words, single write and registered read port) and
// return zero; composite beats read that store and either pass the framebuffer
// pixel, replace it with the masked cursor pixel, or blend it with a
// premultiplied cursor pixel that saturates each byte at 255. Stages: address
// and screen checks, store read, per-byte blend multiply, divide-by-255 and
// output select. Stalls hold every stage; bubbles are squeezed out, so input
// is taken while results wait downstream. Store entries read before they are
// written return unspecified data; no clearing pass runs after reset.
// Write registers only while the pipeline is empty; nothing here enforces it.
`include "cursor_overlay_compositor_assert.svh"

module cursor_overlay_compositor #(
  parameter int MAX_CURSOR_W = coc_pkg::MAX_CURSOR_W_DEF,
  parameter int MAX_CURSOR_H = coc_pkg::MAX_CURSOR_H_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [coc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [coc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [coc_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [coc_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [coc_pkg::PIX_W-1:0]     in_cursor_pixel,
  input  logic                          in_mask_bit,
  input  logic [coc_pkg::PIX_W-1:0]     in_screen_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [coc_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_covered
);

  import coc_pkg::*;

  localparam int DEPTH = MAX_CURSOR_W * MAX_CURSOR_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_CURSOR_W);
  localparam int YW    = $clog2(MAX_CURSOR_H);
  localparam logic [8:0] MaxW9 = 9'(MAX_CURSOR_W);
  localparam logic [8:0] MaxH9 = 9'(MAX_CURSOR_H);
  localparam logic [COORD_W-1:0] MaxWc = COORD_W'(MAX_CURSOR_W);
  localparam logic [COORD_W-1:0] MaxHc = COORD_W'(MAX_CURSOR_H);

  // configuration registers
  logic [POS_W-1:0]  origin_x_r, origin_y_r;
  logic [SIZE_W-1:0] cursor_width_r, cursor_height_r;
  logic [SCR_W-1:0]  screen_width_r, screen_height_r;
  logic              alpha_enable_r;
  logic              any_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      cursor_width_r  <= '0;
      cursor_height_r <= '0;
      screen_width_r  <= SCREEN_RST;
      screen_height_r <= SCREEN_RST;
      alpha_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:      origin_x_r      <= cfg_data[POS_W-1:0];
        CFG_ORIGIN_Y:      origin_y_r      <= cfg_data[POS_W-1:0];
        CFG_CURSOR_WIDTH:  cursor_width_r  <= cfg_data[SIZE_W-1:0];
        CFG_CURSOR_HEIGHT: cursor_height_r <= cfg_data[SIZE_W-1:0];
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[SCR_W-1:0];
        CFG_ALPHA_ENABLE:  alpha_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // flow control, each stage refills when empty or draining
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic en1, en2, en3, en_out;

  assign en_out   = !out_valid_r || !out_stall;
  assign en3      = !s3_v_r || en_out;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    s1_v_r      <= in_valid;
      if (en2)    s2_v_r      <= s1_v_r;
      if (en3)    s3_v_r      <= s2_v_r;
      if (en_out) out_valid_r <= s3_v_r;
    end
  end

  // stage 1: relative position and range checks
  logic              s1_op_r, s1_hit_r, s1_mask_r;
  logic signed [13:0] s1_col_r, s1_row_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic signed [13:0] col_nxt, row_nxt;
  logic              hit_nxt;

  always_comb begin
    if (in_opcode == OP_LOAD) begin
      col_nxt = $signed({2'b00, in_coord_x});
      row_nxt = $signed({2'b00, in_coord_y});
      hit_nxt = (in_coord_x < MaxWc) && (in_coord_y < MaxHc);
    end else begin
      col_nxt = $signed({2'b00, in_coord_x}) - $signed({origin_x_r[POS_W-1], origin_x_r});
      row_nxt = $signed({2'b00, in_coord_y}) - $signed({origin_y_r[POS_W-1], origin_y_r});
      hit_nxt = ({1'b0, in_coord_x} < screen_width_r) &&
                ({1'b0, in_coord_y} < screen_height_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r   <= in_opcode;
      s1_col_r  <= col_nxt;
      s1_row_r  <= row_nxt;
      s1_hit_r  <= hit_nxt;
      s1_mask_r <= in_mask_bit;
      s1_pix_r  <= (in_opcode == OP_LOAD) ? in_cursor_pixel : in_screen_pixel;
    end
  end

  // stage 2: box test, store access, alpha tracking
  logic [8:0]       box_w, box_h;
  logic             inbox;
  logic [AW-1:0]    ram_addr;
  logic             ram_we, ram_re;
  logic [STORE_W-1:0] ram_rdata;
  logic             has_alpha, at_origin;

  assign box_w = ({2'b00, cursor_width_r} > MaxW9) ? MaxW9 : {2'b00, cursor_width_r};
  assign box_h = ({2'b00, cursor_height_r} > MaxH9) ? MaxH9 : {2'b00, cursor_height_r};
  assign inbox = s1_hit_r && !s1_col_r[13] && !s1_row_r[13] &&
                 (s1_col_r[12:0] < {4'b0000, box_w}) &&
                 (s1_row_r[12:0] < {4'b0000, box_h});
  assign ram_addr = AW'(s1_row_r[YW-1:0]) * AW'(MAX_CURSOR_W) + AW'(s1_col_r[XW-1:0]);
  assign ram_we = en2 && s1_v_r && (s1_op_r == OP_LOAD) && s1_hit_r;
  assign ram_re = en2 && s1_v_r && (s1_op_r == OP_COMP) && inbox;
  assign has_alpha = (s1_pix_r[31:24] != 8'h00);
  assign at_origin = (s1_col_r == 14'sd0) && (s1_row_r == 14'sd0);

  coc_ram #(
    .WIDTH(STORE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata ({s1_mask_r, s1_pix_r}),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_alpha_r <= 1'b0;
    end else if (ram_we) begin
      any_alpha_r <= at_origin ? has_alpha : (any_alpha_r || has_alpha);
    end
  end

  logic             s2_op_r, s2_cov_r, s2_blend_r;
  logic [PIX_W-1:0] s2_pix_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op_r    <= s1_op_r;
      s2_cov_r   <= (s1_op_r == OP_COMP) && inbox;
      s2_blend_r <= alpha_enable_r && any_alpha_r;
      s2_pix_r   <= s1_pix_r;
    end
  end

  // stage 3: per-byte (255 - alpha) * fb products
  logic [15:0] prod_nxt [4];
  logic [7:0]  inv_alpha;

  assign inv_alpha = 8'hff - ram_rdata[31:24];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = 16'(inv_alpha) * 16'(s2_pix_r[8*i +: 8]);
    end
  end

  logic             s3_op_r, s3_cov_r, s3_blend_r, s3_cmask_r;
  logic [PIX_W-1:0] s3_spix_r, s3_cpix_r;
  logic [15:0]      s3_prod_r [4];

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_op_r    <= s2_op_r;
      s3_cov_r   <= s2_cov_r;
      s3_blend_r <= s2_blend_r;
      s3_spix_r  <= s2_pix_r;
      s3_cpix_r  <= ram_rdata[PIX_W-1:0];
      s3_cmask_r <= ram_rdata[PIX_W];
      for (int i = 0; i < 4; i++) begin
        s3_prod_r[i] <= prod_nxt[i];
      end
    end
  end

  // stage 4: divide, saturating add, result select
  logic [PIX_W-1:0] blend_pix;
  logic [8:0]       byte_sum [4];
  logic [PIX_W-1:0] pixel_nxt;
  logic             covered_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      byte_sum[i] = 9'(s3_cpix_r[8*i +: 8]) + 9'(div255(s3_prod_r[i]));
      blend_pix[8*i +: 8] = byte_sum[i][8] ? 8'hff : byte_sum[i][7:0];
    end
  end

  always_comb begin
    pixel_nxt   = s3_spix_r;
    covered_nxt = s3_cov_r;
    if (s3_op_r == OP_LOAD) begin
      pixel_nxt   = '0;
      covered_nxt = 1'b0;
    end else if (s3_cov_r) begin
      if (s3_blend_r) begin
        pixel_nxt = blend_pix;
      end else if (s3_cmask_r) begin
        pixel_nxt = s3_cpix_r;
      end
    end
  end

  logic [PIX_W-1:0] out_pixel_r;
  logic             out_covered_r;

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_pixel_r   <= pixel_nxt;
      out_covered_r <= covered_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pixel_r;
  assign out_covered = out_covered_r;

  `COC_ASSERT_IMPL(a_stall_only_full, in_stall, s1_v_r && s2_v_r && s3_v_r && out_valid_r && out_stall, "input stalled with room in pipeline")
  `COC_ASSERT_NEVER(a_store_one_port, ram_we && ram_re, "store written and read in one cycle")
  `COC_ASSERT_IMPL(a_load_uncovered, s2_v_r && (s2_op_r == OP_LOAD), !s2_cov_r, "load beat marked covered")

endmodule
